// ===== hw/rtl/bfp_pkg.sv =====
// Shared types and constants of the Bellman-Ford path finder.
// No dependencies.
package bfp_pkg;

    localparam int MaxNodes    = 32;
    localparam int MaxEdges    = 256;
    localparam int NodeBits    = 5;
    localparam int EdgeBits    = 8;
    localparam int WeightBits  = 16;
    localparam int DistBits    = 24;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;

    localparam logic [5:0] NODE_COUNT_RESET = 6'd32;

    typedef struct packed {
        logic [1:0]               operation;
        logic [NodeBits-1:0]      from_node;
        logic [NodeBits-1:0]      to_node;
        logic signed [WeightBits-1:0] edge_weight;
    } in_item_t;

    typedef struct packed {
        logic [NodeBits-1:0] route_node;
        logic                is_last;
        logic                negative_cycle;
    } out_item_t;

endpackage

// ===== hw/rtl/bellman_ford_path_finder.sv =====
// Bellman-Ford path finder top level: edge store, distance memory, sequencer.
// Depends on bfp_pkg.
//
// Usage: input transactions on in_valid/in_stall/in_data carry one of three
// operations. Add edge stores (tail, head, weight) in the next free entry of
// the 256-entry edge store; clear empties it. Both produce nothing. Find path
// runs node_count-1 relaxation rounds and one check round over the stored
// edges. In each round every edge is read from the single edge memory, then
// the distance memory is read for its tail and head; a used edge then takes a
// read-modify-write of the head distance, a skipped edge goes straight on.
// The route is then walked back from the destination before it is sent.
// One query is worked on at a time; in_stall is high until it is done.
// Results leave on out_valid/out_stall/out_data, one node per transaction,
// source first, is_last on the final one; a negative cycle gives a single
// transaction with negative_cycle set. A stalled result holds in the output
// register and the next result waits. Reset clears the edge count, the output
// register and sets node_count to 32; no clearing pass is needed.
// APB writes to any address set node_count; reads return it at byte address 0.
module bellman_ford_path_finder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bfp_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bfp_pkg::out_item_t   out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DREAD = 3'd3;
    localparam logic [2:0] ST_RELAX = 3'd4;
    localparam logic [2:0] ST_WALK  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam int EdgeW = 2 * bfp_pkg::NodeBits + bfp_pkg::WeightBits;
    localparam int DW    = bfp_pkg::DistBits;

    logic [EdgeW-1:0]            edge_mem [bfp_pkg::MaxEdges];
    logic [DW-1:0]               dist_mem [bfp_pkg::MaxNodes];
    logic [bfp_pkg::NodeBits-1:0] stack_reg [bfp_pkg::MaxNodes];
    logic [5:0]                  pred_reg [bfp_pkg::MaxNodes];
    logic [bfp_pkg::MaxNodes-1:0] reached_reg;

    logic [2:0]  state_reg;
    logic [5:0]  node_count_reg;
    logic [8:0]  edge_total_reg;
    logic [8:0]  edge_idx_reg;
    logic [4:0]  round_reg;
    logic        apply_reg;
    logic        found_reg;
    logic        neg_reg;
    logic [4:0]  src_reg;
    logic [4:0]  dst_reg;
    logic [EdgeW-1:0] edge_q_reg;
    logic [DW-1:0] dx_q_reg;
    logic [DW-1:0] dy_q_reg;
    logic [5:0]  cur_reg;
    logic [5:0]  len_reg;
    logic [4:0]  emit_idx_reg;
    logic        out_valid_reg;
    bfp_pkg::out_item_t out_data_reg;

    logic [5:0]  n_act;
    logic        in_acc;
    logic        out_free;
    logic [4:0]  e_tail;
    logic [4:0]  e_head;
    logic [15:0] e_cost;
    logic        e_use;
    logic signed [DW:0] sum;
    logic signed [DW:0] dy_ext;
    logic        relax;
    logic [DW-1:0] sum_sat;
    logic        add_ok;
    logic        dist_we;
    logic [4:0]  dist_wa;
    logic [DW-1:0] dist_wd;

    always_comb
    begin
        if (node_count_reg == 6'd0)
            n_act = 6'd1;
        else if (node_count_reg > 6'(bfp_pkg::MaxNodes))
            n_act = 6'(bfp_pkg::MaxNodes);
        else
            n_act = node_count_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pready    = 1'b1;
    assign prdata    = (paddr == bfp_pkg::REG_NODE_COUNT) ? {26'd0, node_count_reg} : 32'd0;

    assign e_tail = edge_q_reg[EdgeW-1 -: 5];
    assign e_head = edge_q_reg[EdgeW-6 -: 5];
    assign e_cost = edge_q_reg[15:0];
    assign e_use  = ({1'b0, e_tail} < n_act) && ({1'b0, e_head} < n_act)
                    && reached_reg[e_tail];
    assign sum    = $signed({dx_q_reg[DW-1], dx_q_reg})
                    + $signed({{(DW+1-16){e_cost[15]}}, e_cost});
    assign dy_ext = $signed({dy_q_reg[DW-1], dy_q_reg});
    assign relax  = !reached_reg[e_head] || (dy_ext > sum);
    assign sum_sat = (sum[DW] != sum[DW-1])
                     ? (sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                     : sum[DW-1:0];
    assign add_ok = ({1'b0, in_data.from_node} < n_act)
                    && ({1'b0, in_data.to_node} < n_act)
                    && (edge_total_reg < 9'(bfp_pkg::MaxEdges));

    always_comb
    begin
        dist_we = 1'b0;
        dist_wa = e_head;
        dist_wd = sum_sat;
        if (state_reg == ST_INIT)
        begin
            dist_we = 1'b1;
            dist_wa = src_reg;
            dist_wd = '0;
        end
        else if (state_reg == ST_RELAX && relax && apply_reg)
        begin
            dist_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.operation == bfp_pkg::OP_ADD && add_ok)
            edge_mem[edge_total_reg[7:0]] <= {in_data.from_node, in_data.to_node,
                                              in_data.edge_weight};
        if (state_reg == ST_SWEEP)
            edge_q_reg <= edge_mem[edge_idx_reg[7:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        if (state_reg == ST_DREAD)
        begin
            dx_q_reg <= dist_mem[e_tail];
            dy_q_reg <= dist_mem[e_head];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WALK && !cur_reg[5] && len_reg < n_act)
            stack_reg[len_reg[4:0]] <= cur_reg[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= bfp_pkg::NODE_COUNT_RESET;
            edge_total_reg <= '0;
            edge_idx_reg   <= '0;
            round_reg      <= '0;
            apply_reg      <= 1'b0;
            found_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            src_reg        <= '0;
            dst_reg        <= '0;
            cur_reg        <= '0;
            len_reg        <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            reached_reg    <= '0;
            for (int i = 0; i < bfp_pkg::MaxNodes; i++)
                pred_reg[i] <= 6'(bfp_pkg::MaxNodes);
        end
        else
        begin
            if (psel && penable && pwrite)
                node_count_reg <= pwdata[5:0];
            if (out_valid_reg && !out_stall && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (in_data.operation)
                            bfp_pkg::OP_ADD:
                            begin
                                if (add_ok)
                                    edge_total_reg <= edge_total_reg + 9'd1;
                            end
                            bfp_pkg::OP_CLEAR:
                                edge_total_reg <= '0;
                            bfp_pkg::OP_FIND:
                            begin
                                src_reg   <= ({1'b0, in_data.from_node} < n_act)
                                             ? in_data.from_node : 5'd0;
                                dst_reg   <= ({1'b0, in_data.to_node} < n_act)
                                             ? in_data.to_node : 5'd0;
                                state_reg <= ST_INIT;
                            end
                            default:
                                ;
                        endcase
                    end
                end
                ST_INIT:
                begin
                    reached_reg <= {{(bfp_pkg::MaxNodes-1){1'b0}}, 1'b1} << src_reg;
                    for (int i = 0; i < bfp_pkg::MaxNodes; i++)
                        pred_reg[i] <= 6'(bfp_pkg::MaxNodes);
                    edge_idx_reg <= '0;
                    round_reg    <= '0;
                    apply_reg    <= (n_act > 6'd1);
                    found_reg    <= 1'b0;
                    state_reg    <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    if (edge_idx_reg == edge_total_reg)
                    begin
                        edge_idx_reg <= '0;
                        if (apply_reg)
                        begin
                            round_reg <= round_reg + 5'd1;
                            if ({1'b0, round_reg} + 6'd2 == n_act)
                            begin
                                apply_reg <= 1'b0;
                                found_reg <= 1'b0;
                            end
                        end
                        else if (found_reg)
                        begin
                            neg_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            neg_reg   <= 1'b0;
                            cur_reg   <= {1'b0, dst_reg};
                            len_reg   <= '0;
                            state_reg <= ST_WALK;
                        end
                    end
                    else
                        state_reg <= ST_DREAD;
                end
                ST_DREAD:
                begin
                    if (e_use)
                        state_reg <= ST_RELAX;
                    else
                    begin
                        edge_idx_reg <= edge_idx_reg + 9'd1;
                        state_reg    <= ST_SWEEP;
                    end
                end
                ST_RELAX:
                begin
                    if (relax)
                    begin
                        found_reg <= 1'b1;
                        if (apply_reg)
                        begin
                            reached_reg[e_head] <= 1'b1;
                            pred_reg[e_head]    <= {1'b0, e_tail};
                        end
                    end
                    edge_idx_reg <= edge_idx_reg + 9'd1;
                    state_reg    <= ST_SWEEP;
                end
                ST_WALK:
                begin
                    if (!cur_reg[5] && len_reg < n_act)
                    begin
                        cur_reg <= pred_reg[cur_reg[4:0]];
                        len_reg <= len_reg + 6'd1;
                    end
                    else
                    begin
                        emit_idx_reg <= 5'(len_reg - 6'd1);
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (neg_reg)
                        begin
                            out_data_reg.route_node     <= '0;
                            out_data_reg.is_last        <= 1'b1;
                            out_data_reg.negative_cycle <= 1'b1;
                            state_reg                   <= ST_IDLE;
                        end
                        else
                        begin
                            out_data_reg.route_node     <= stack_reg[emit_idx_reg];
                            out_data_reg.is_last        <= (emit_idx_reg == 5'd0);
                            out_data_reg.negative_cycle <= 1'b0;
                            if (emit_idx_reg == 5'd0)
                                state_reg <= ST_IDLE;
                            else
                                emit_idx_reg <= emit_idx_reg - 5'd1;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
